@@ rtl/core/vds_pkg.sv @@
package vds_pkg;

    localparam int MAX_SIZE_X   = 64;
    localparam int MAX_SIZE_Y   = 64;
    localparam int MAX_SIZE_Z   = 64;
    localparam int SAMPLE_WIDTH = 32;

    localparam int NCOMP       = 3;
    localparam int POS_W       = 6;
    localparam int CFG_SIZE_W  = 7;
    localparam int OP_W        = 2;
    localparam int RECIP_W     = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int MAX_DIM_XY = (MAX_SIZE_X > MAX_SIZE_Y) ? MAX_SIZE_X : MAX_SIZE_Y;
    localparam int MAX_DIM    = (MAX_DIM_XY > MAX_SIZE_Z) ? MAX_DIM_XY : MAX_SIZE_Z;
    localparam int DIM_W      = $clog2(MAX_DIM + 1);
    localparam int SIZE_W     = (DIM_W > CFG_SIZE_W) ? DIM_W : CFG_SIZE_W;
    localparam int CMP_W      = SIZE_W + 1;

    localparam int COL_W   = $clog2(MAX_SIZE_X);
    localparam int ROW_W   = $clog2(MAX_SIZE_Y);
    localparam int PLANE_W = $clog2(MAX_SIZE_Z);

    localparam int PLANE_WORDS = MAX_SIZE_X * MAX_SIZE_Y;
    localparam int HIST_DEPTH  = 2 * PLANE_WORDS;
    localparam int ADDR_W      = $clog2(HIST_DEPTH);
    localparam int VOXEL_W     = NCOMP * SAMPLE_WIDTH;

    localparam int TAPS       = 6;
    localparam int TAP_CENTER = 0;
    localparam int TAP_XP     = 1;
    localparam int TAP_XM     = 2;
    localparam int TAP_YP     = 3;
    localparam int TAP_YM     = 4;
    localparam int TAP_ZM     = 5;

    localparam int DIFF_W      = SAMPLE_WIDTH + 1;
    localparam int ACC_W       = SAMPLE_WIDTH + 4;
    localparam int LO_W        = 32;
    localparam int MAG_W       = (ACC_W > LO_W + 1) ? ACC_W : LO_W + 1;
    localparam int HI_W        = MAG_W - LO_W;
    localparam int PROD_LO_W   = LO_W + RECIP_W;
    localparam int PROD_HI_W   = HI_W + RECIP_W;
    localparam int FRAC_W      = 16;
    localparam int RND_W       = PROD_LO_W + 1;
    localparam int Q_A_W       = RND_W - FRAC_W;
    localparam int Q_B_W       = PROD_HI_W + FRAC_W;
    localparam int Q_W         = ((Q_A_W > Q_B_W) ? Q_A_W : Q_B_W) + 1;
    localparam int ROUND_HALF  = 1 << (FRAC_W - 1);
    localparam int HI_LIMIT_SH = 47;

    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_SIZE_W-1:0] SIZE_RESET       = CFG_SIZE_W'(64);
    localparam logic [RECIP_W-1:0]    HALF_STEP_RESET  = RECIP_W'(32768);
    localparam logic [RECIP_W-1:0]    STEP_SQ_RESET    = RECIP_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_GRADIENT   = 2'd0,
        OP_DIVERGENCE = 2'd1,
        OP_CURL       = 2'd2,
        OP_LAPLACIAN  = 2'd3
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SIZE_X          = 3'd0,
        REG_SIZE_Y          = 3'd1,
        REG_SIZE_Z          = 3'd2,
        REG_OPERATION       = 3'd3,
        REG_HALF_STEP_RECIP = 3'd4,
        REG_STEP_SQ_RECIP   = 3'd5
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] comp_x;
        logic signed [SAMPLE_WIDTH-1:0] comp_y;
        logic signed [SAMPLE_WIDTH-1:0] comp_z;
    } voxel_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] res_x;
        logic signed [SAMPLE_WIDTH-1:0] res_y;
        logic signed [SAMPLE_WIDTH-1:0] res_z;
        logic [POS_W-1:0]               pos_i;
        logic [POS_W-1:0]               pos_j;
        logic [POS_W-1:0]               pos_k;
        logic                           grid_done;
        logic                           saturated;
    } result_t;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos_i;
        logic [POS_W-1:0] pos_j;
        logic [POS_W-1:0] pos_k;
        logic             grid_done;
    } tag_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_SIZE_W-1:0] v,
                                                      input int maxv);
        logic [SIZE_W-1:0] r;
        if (int'(v) < 3)
            r = SIZE_W'(3);
        else if (int'(v) > maxv)
            r = SIZE_W'(maxv);
        else
            r = SIZE_W'(v);
        return r;
    endfunction

endpackage

@@ rtl/core/vds_ram.sv @@
module vds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/vds_scan.sv @@
module vds_scan
    import vds_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [CFG_SIZE_W-1:0]          size_x,
    input  logic [CFG_SIZE_W-1:0]          size_y,
    input  logic [CFG_SIZE_W-1:0]          size_z,
    output tag_t                           tag,
    output logic [TAPS-1:0][ADDR_W-1:0]    rd_addr,
    output logic [ADDR_W-1:0]              wr_addr
);

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [CMP_W-1:0]   sx, sy, sz, cw, rw, pw;
    logic               interior;
    logic [ADDR_W-1:0]  cur_base, oth_base, row_off, center;

    assign sx = CMP_W'(clamp_size(size_x, MAX_SIZE_X));
    assign sy = CMP_W'(clamp_size(size_y, MAX_SIZE_Y));
    assign sz = CMP_W'(clamp_size(size_z, MAX_SIZE_Z));
    assign cw = CMP_W'(col_reg);
    assign rw = CMP_W'(row_reg);
    assign pw = CMP_W'(plane_reg);

    assign interior = (cw >= CMP_W'(1)) && (cw + CMP_W'(2) <= sx)
                   && (rw >= CMP_W'(1)) && (rw + CMP_W'(2) <= sy)
                   && (pw >= CMP_W'(2)) && (pw + CMP_W'(1) <= sz);

    assign tag.valid     = advance && interior;
    assign tag.pos_i     = POS_W'(col_reg);
    assign tag.pos_j     = POS_W'(row_reg);
    assign tag.pos_k     = POS_W'(pw - CMP_W'(1));
    assign tag.grid_done = (cw + CMP_W'(2) == sx) && (rw + CMP_W'(2) == sy)
                        && (pw + CMP_W'(1) == sz);

    assign cur_base = plane_reg[0] ? ADDR_W'(PLANE_WORDS) : '0;
    assign oth_base = plane_reg[0] ? '0 : ADDR_W'(PLANE_WORDS);
    assign row_off  = ADDR_W'(row_reg) * ADDR_W'(MAX_SIZE_X);
    assign center   = oth_base + row_off + ADDR_W'(col_reg);
    assign wr_addr  = cur_base + row_off + ADDR_W'(col_reg);

    assign rd_addr[TAP_CENTER] = center;
    assign rd_addr[TAP_XP]     = center + ADDR_W'(1);
    assign rd_addr[TAP_XM]     = center - ADDR_W'(1);
    assign rd_addr[TAP_YP]     = center + ADDR_W'(MAX_SIZE_X);
    assign rd_addr[TAP_YM]     = center - ADDR_W'(MAX_SIZE_X);
    assign rd_addr[TAP_ZM]     = wr_addr;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        plane_next = plane_reg;
        if (advance)
        begin
            if (cw + CMP_W'(1) >= sx)
            begin
                col_next = '0;
                if (rw + CMP_W'(1) >= sy)
                begin
                    row_next = '0;
                    if (pw + CMP_W'(1) >= sz)
                        plane_next = '0;
                    else
                        plane_next = plane_reg + PLANE_W'(1);
                end
                else
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            plane_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            plane_reg <= plane_next;
        end
    end

endmodule

@@ rtl/core/vds_stencil.sv @@
module vds_stencil
    import vds_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  tag_t                         tag,
    input  voxel_t                       voxel,
    input  logic [TAPS-1:0][VOXEL_W-1:0] rd_data,
    input  op_t                          operation,
    input  logic [RECIP_W-1:0]           half_step_recip,
    input  logic [RECIP_W-1:0]           step_sq_recip,
    output logic                         push,
    output result_t                      push_item
);

    tag_t   s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg, s5_tag_reg;
    voxel_t s1_up_reg;

    logic signed [SAMPLE_WIDTH-1:0] c [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] xp [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] xm [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] yp [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] ym [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] zp [NCOMP];
    logic signed [SAMPLE_WIDTH-1:0] zm [NCOMP];

    logic signed [DIFF_W-1:0] dx_reg [NCOMP];
    logic signed [DIFF_W-1:0] dy_reg [NCOMP];
    logic signed [DIFF_W-1:0] dz_reg [NCOMP];
    logic signed [DIFF_W-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [ACC_W-1:0]  c6_reg;

    logic signed [ACC_W-1:0]  acc [NCOMP];
    logic signed [ACC_W-1:0]  acc_reg [NCOMP];
    logic signed [ACC_W-1:0]  acc_neg [NCOMP];

    logic                     neg4_reg [NCOMP];
    logic [MAG_W-1:0]         mag_reg [NCOMP];
    logic                     neg5_reg [NCOMP];
    logic [PROD_LO_W-1:0]     plo_reg [NCOMP];
    logic [PROD_HI_W-1:0]     phi_reg [NCOMP];
    logic [RECIP_W-1:0]       recip;
    logic [SAMPLE_WIDTH:0]    fin [NCOMP];

    function automatic logic [SAMPLE_WIDTH:0] finish(input logic neg,
                                                     input logic [PROD_LO_W-1:0] plo,
                                                     input logic [PROD_HI_W-1:0] phi);
        logic [RND_W-1:0]        rnd;
        logic [Q_W-1:0]          q;
        logic [Q_W-1:0]          lim;
        logic                    sat;
        logic [SAMPLE_WIDTH-1:0] val;
        rnd = (RND_W'(plo) + RND_W'(ROUND_HALF)) >> FRAC_W;
        q   = Q_W'(rnd) + (Q_W'(phi) << FRAC_W);
        lim = neg ? (Q_W'(1) << (SAMPLE_WIDTH - 1))
                  : (Q_W'(1) << (SAMPLE_WIDTH - 1)) - Q_W'(1);
        sat = ((phi >> HI_LIMIT_SH) != '0) || (q > lim);
        val = sat ? lim[SAMPLE_WIDTH-1:0] : q[SAMPLE_WIDTH-1:0];
        if (neg)
            val = -val;
        return {sat, val};
    endfunction

    always_comb
    begin
        for (int m = 0; m < NCOMP; m++)
        begin
            c[m]  = rd_data[TAP_CENTER][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            xp[m] = rd_data[TAP_XP][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            xm[m] = rd_data[TAP_XM][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            yp[m] = rd_data[TAP_YP][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            ym[m] = rd_data[TAP_YM][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            zm[m] = rd_data[TAP_ZM][VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
            zp[m] = s1_up_reg[VOXEL_W-1-m*SAMPLE_WIDTH -: SAMPLE_WIDTH];
        end
    end

    always_comb
    begin
        for (int m = 0; m < NCOMP; m++)
        begin
            acc[m] = '0;
        end
        case (operation)
            OP_GRADIENT:
            begin
                acc[0] = ACC_W'(dx_reg[0]);
                acc[1] = ACC_W'(dy_reg[0]);
                acc[2] = ACC_W'(dz_reg[0]);
            end
            OP_DIVERGENCE:
            begin
                acc[0] = ACC_W'(dx_reg[0]) + ACC_W'(dy_reg[1]) + ACC_W'(dz_reg[2]);
            end
            OP_CURL:
            begin
                acc[0] = ACC_W'(dy_reg[2]) - ACC_W'(dz_reg[1]);
                acc[1] = ACC_W'(dz_reg[0]) - ACC_W'(dx_reg[2]);
                acc[2] = ACC_W'(dx_reg[1]) - ACC_W'(dy_reg[0]);
            end
            OP_LAPLACIAN:
            begin
                acc[0] = ACC_W'(sum_x_reg) + ACC_W'(sum_y_reg) + ACC_W'(sum_z_reg) - c6_reg;
            end
            default:
            begin
                acc[0] = '0;
            end
        endcase
    end

    assign recip = (operation == OP_LAPLACIAN) ? step_sq_recip : half_step_recip;

    always_comb
    begin
        for (int m = 0; m < NCOMP; m++)
        begin
            acc_neg[m] = -acc_reg[m];
            fin[m]     = finish(neg5_reg[m], plo_reg[m], phi_reg[m]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= tag;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_up_reg <= voxel;
        for (int m = 0; m < NCOMP; m++)
        begin
            dx_reg[m]   <= DIFF_W'(xp[m]) - DIFF_W'(xm[m]);
            dy_reg[m]   <= DIFF_W'(yp[m]) - DIFF_W'(ym[m]);
            dz_reg[m]   <= DIFF_W'(zp[m]) - DIFF_W'(zm[m]);
            acc_reg[m]  <= acc[m];
            neg4_reg[m] <= acc_reg[m][ACC_W-1];
            mag_reg[m]  <= acc_reg[m][ACC_W-1] ? MAG_W'($unsigned(acc_neg[m]))
                                               : MAG_W'($unsigned(acc_reg[m]));
            neg5_reg[m] <= neg4_reg[m];
            plo_reg[m]  <= PROD_LO_W'(mag_reg[m][LO_W-1:0]) * PROD_LO_W'(recip);
            phi_reg[m]  <= PROD_HI_W'(mag_reg[m][MAG_W-1:LO_W]) * PROD_HI_W'(recip);
        end
        sum_x_reg <= DIFF_W'(xp[0]) + DIFF_W'(xm[0]);
        sum_y_reg <= DIFF_W'(yp[0]) + DIFF_W'(ym[0]);
        sum_z_reg <= DIFF_W'(zp[0]) + DIFF_W'(zm[0]);
        c6_reg    <= (ACC_W'(c[0]) <<< 2) + (ACC_W'(c[0]) <<< 1);
    end

    assign push                = s5_tag_reg.valid;
    assign push_item.res_x     = fin[0][SAMPLE_WIDTH-1:0];
    assign push_item.res_y     = fin[1][SAMPLE_WIDTH-1:0];
    assign push_item.res_z     = fin[2][SAMPLE_WIDTH-1:0];
    assign push_item.pos_i     = s5_tag_reg.pos_i;
    assign push_item.pos_j     = s5_tag_reg.pos_j;
    assign push_item.pos_k     = s5_tag_reg.pos_k;
    assign push_item.grid_done = s5_tag_reg.grid_done;
    assign push_item.saturated = fin[0][SAMPLE_WIDTH] | fin[1][SAMPLE_WIDTH]
                               | fin[2][SAMPLE_WIDTH];

endmodule

@@ rtl/core/vds_queue.sv @@
module vds_queue
    import vds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    reserve,
    input  logic    push,
    input  result_t push_item,
    output logic    valid,
    input  logic    stall,
    output result_t item,
    output logic    full
);

    result_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_CNT_W-1:0] credit_reg, credit_next;
    logic                   pop;

    assign valid = count_reg != '0;
    assign pop   = valid && !stall;
    assign item  = slot_reg[rd_ptr_reg];
    assign full  = credit_reg == QUEUE_CNT_W'(QUEUE_DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_PTR_W'(1);
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        credit_next = credit_reg + QUEUE_CNT_W'(reserve) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            credit_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            credit_reg <= credit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/core/voxel_difference_stencil_core.sv @@
// Seven-point central-difference engine for a streamed three-component voxel
// field (signed Q16.16, raster order, x fastest). It takes one voxel per clock
// while voxel_stall is low; the voxel at (i, j, k+1) completes the stencil of
// center (i, j, k), whose result goes via registers s1 to s5 to the output
// queue, held there by result_stall. Edge voxels and planes 0 and 1 are stored
// but give no result. Neighbor reads come from six copies of a two-plane
// history RAM (one per stencil tap, registered read), all written with the
// incoming voxel, so no read ever waits on a write. voxel_stall rises only
// when eight results (queue depth) are queued or in flight. The user must
// write configuration between grids, with the block drained; not enforced.
module voxel_difference_stencil_core
    import vds_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   voxel_valid,
    output logic                   voxel_stall,
    input  voxel_t                 voxel,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_wen,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CFG_SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    op_t                   operation_reg;
    logic [RECIP_W-1:0]    half_step_recip_reg, step_sq_recip_reg;

    logic                         accept;
    logic                         full;
    tag_t                         tag;
    logic [TAPS-1:0][ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]            wr_addr;
    logic [TAPS-1:0][VOXEL_W-1:0] rd_data;
    logic                         push;
    result_t                      push_item;

    assign voxel_stall = full;
    assign accept      = voxel_valid && !voxel_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg          <= SIZE_RESET;
            size_y_reg          <= SIZE_RESET;
            size_z_reg          <= SIZE_RESET;
            operation_reg       <= OP_GRADIENT;
            half_step_recip_reg <= HALF_STEP_RESET;
            step_sq_recip_reg   <= STEP_SQ_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_SIZE_X:          size_x_reg          <= cfg_data[CFG_SIZE_W-1:0];
                REG_SIZE_Y:          size_y_reg          <= cfg_data[CFG_SIZE_W-1:0];
                REG_SIZE_Z:          size_z_reg          <= cfg_data[CFG_SIZE_W-1:0];
                REG_OPERATION:       operation_reg       <= op_t'(cfg_data[OP_W-1:0]);
                REG_HALF_STEP_RECIP: half_step_recip_reg <= cfg_data[RECIP_W-1:0];
                REG_STEP_SQ_RECIP:   step_sq_recip_reg   <= cfg_data[RECIP_W-1:0];
                default:             size_x_reg          <= size_x_reg;
            endcase
        end
    end

    vds_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .size_x  (size_x_reg),
        .size_y  (size_y_reg),
        .size_z  (size_z_reg),
        .tag     (tag),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr)
    );

    for (genvar t = 0; t < TAPS; t++)
    begin : g_hist
        vds_ram #(
            .WIDTH (VOXEL_W),
            .DEPTH (HIST_DEPTH)
        ) u_hist (
            .clk   (clk),
            .we    (accept),
            .waddr (wr_addr),
            .wdata (voxel),
            .raddr (rd_addr[t]),
            .rdata (rd_data[t])
        );
    end

    vds_stencil u_stencil (
        .clk             (clk),
        .rst_n           (rst_n),
        .tag             (tag),
        .voxel           (voxel),
        .rd_data         (rd_data),
        .operation       (operation_reg),
        .half_step_recip (half_step_recip_reg),
        .step_sq_recip   (step_sq_recip_reg),
        .push            (push),
        .push_item       (push_item)
    );

    vds_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .reserve   (tag.valid),
        .push      (push),
        .push_item (push_item),
        .valid     (result_valid),
        .stall     (result_stall),
        .item      (result),
        .full      (full)
    );

`ifndef SYNTHESIS
    a_center_reaches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        tag.valid |-> ##5 push)
        else $error("stencil result did not reach the queue");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> result_valid)
        else $error("queued result not presented");

    a_interior_position: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pos_i != '0) && (result.pos_j != '0)
                         && (result.pos_k != '0))
        else $error("result position on the grid boundary");
`endif

endmodule
